FILE: hw/rtl/efba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// efba_pkg: shared types and constants of the exact-fit block allocator
// Field widths, register indexes, request modes, status codes and the
// sequencer state type.
// ----------------------------------------------------------------------------
package efba_pkg;

  // Fixed field widths
  localparam int ADDR_W     = 32;  // data addresses and heap base
  localparam int REQ_W      = 24;  // request size field
  localparam int OFF_W      = 25;  // block offsets and used byte count
  localparam int LEN_W      = 25;  // heap length register
  localparam int END_W      = 27;  // used + header + size, no overflow
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_LENGTH = 1'b1;

  // Request modes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_REUSED = 3'd0,
    STAT_NEW    = 3'd1,
    STAT_NOMEM  = 3'd2,
    STAT_FREED  = 3'd3,
    STAT_REJECT = 3'd4,
    STAT_NULL   = 3'd5
  } efba_status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HIT,
    ST_CARVE
  } efba_state_e;

endpackage : efba_pkg
`default_nettype wire

FILE: hw/rtl/efba_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// efba_table: block table memory
// One write port and one read port with registered read data. Holds one
// entry per block: in-use flag, size and offset.
// ----------------------------------------------------------------------------
module efba_table #(
  parameter int DEPTH  = 256,
  parameter int DATA_W = 50
) (
  input  wire logic                       clk_i,
  input  wire logic                       rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr_i,
  output      logic [DATA_W-1:0]          rd_data_o,
  input  wire logic                       wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr_i,
  input  wire logic [DATA_W-1:0]          wr_data_i
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read one entry, data valid the next cycle
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule : efba_table
`default_nettype wire

FILE: hw/rtl/exact_fit_block_allocator.sv
`default_nettype none
// A null free shows its result in the cycle after start. Other requests scan the table
// one entry per cycle and stop at the first match; a free with no match then reports a reject,
// and an alloc with no match carves a new block or reports out of memory.
// Throughput: one request at a time; busy_o is high while a scan runs; a null free never raises it.
// The result strobe lasts one cycle and cannot be stalled.
// Reset clears the block count, used bytes and both registers; table is not cleared.
// ----------------------------------------------------------------------------
// exact_fit_block_allocator: exact-fit free list with a bump allocator
// Allocate reuses the oldest free block of exactly the requested size or
// carves a new block at the bump offset; free releases the block whose data
// address matches.
// ----------------------------------------------------------------------------
module exact_fit_block_allocator #(
  parameter int MAX_BLOCKS   = 256,
  parameter int HEADER_BYTES = 40,
  parameter int SIZE_BITS    = 24
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration write port
  input  wire logic                               cfg_we_i,
  input  wire logic [efba_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [efba_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // request
  input  wire logic                               start_i,
  input  wire logic                               mode_i,
  input  wire logic [efba_pkg::REQ_W-1:0]         request_size_i,
  input  wire logic [efba_pkg::ADDR_W-1:0]        free_address_i,
  output      logic                               busy_o,
  // result
  output      logic                               done_o,
  output      logic [efba_pkg::ADDR_W-1:0]        address_o,
  output      logic [2:0]                         status_o
);
  import efba_pkg::*;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int SZ_W  = (SIZE_BITS < REQ_W) ? SIZE_BITS : REQ_W;
  localparam int ENT_W = 1 + SZ_W + OFF_W;
  localparam logic [ADDR_W-1:0] HdrAddr = ADDR_W'(HEADER_BYTES);
  localparam logic [END_W-1:0]  HdrEnd  = END_W'(HEADER_BYTES);
  localparam logic [CNT_W-1:0]  CntMax  = CNT_W'(MAX_BLOCKS);

  // Control state
  efba_state_e       state_q, state_d;
  logic [CNT_W-1:0]  count_q, idx_q;
  logic              chk_vld_q;
  logic [OFF_W-1:0]  used_q;
  logic [ADDR_W-1:0] heap_base_q;
  logic [LEN_W-1:0]  heap_len_q;
  logic              done_q;

  // Request payload
  logic              mode_q;
  logic [SZ_W-1:0]   size_q;
  logic [ADDR_W-1:0] target_q;
  logic [ENT_W-1:0]  hit_q;
  logic [IDX_W-1:0]  hit_idx_q;
  logic [ADDR_W-1:0] address_q;
  efba_status_e      status_q;

  // Table port
  logic              rd_en, wr_en;
  logic [ENT_W-1:0]  rd_data, wr_data;
  logic [IDX_W-1:0]  wr_addr;

  // Result
  logic              res_set;
  logic [ADDR_W-1:0] res_address;
  efba_status_e      res_status;

  efba_table #(
    .DEPTH  (MAX_BLOCKS),
    .DATA_W (ENT_W)
  ) u_table (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (idx_q[IDX_W-1:0]),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // Compare the entry read last cycle against the request
  logic             rd_in_use, hit_in_use, match, accept, null_free, scan_end, carve_ok;
  logic [SZ_W-1:0]  rd_size, hit_size;
  logic [OFF_W-1:0] rd_off, hit_off;
  logic [END_W-1:0] end_w;

  assign rd_in_use  = rd_data[ENT_W-1];
  assign rd_size    = rd_data[ENT_W-2:OFF_W];
  assign rd_off     = rd_data[OFF_W-1:0];
  assign hit_in_use = hit_q[ENT_W-1];
  assign hit_size   = hit_q[ENT_W-2:OFF_W];
  assign hit_off    = hit_q[OFF_W-1:0];

  assign match = chk_vld_q &&
                 ((mode_q == MODE_FREE) ? (ADDR_W'(rd_off) == target_q)
                                        : (!rd_in_use && (rd_size == size_q)));
  assign scan_end  = !match && (idx_q == count_q);
  assign accept    = start_i && (state_q == ST_IDLE);
  assign null_free = (mode_i == MODE_FREE) && (free_address_i == '0);

  // Bump check: block must end strictly below the heap length and the table must not be full
  assign end_w    = END_W'(used_q) + HdrEnd + END_W'(size_q);
  assign carve_ok = (end_w < END_W'(heap_len_q)) && (count_q != CntMax);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && !null_free) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match) begin
          state_d = ST_HIT;
        end else if (scan_end) begin
          state_d = (mode_q == MODE_ALLOC) ? ST_CARVE : ST_IDLE;
        end
      end
      ST_HIT:   state_d = ST_IDLE;
      ST_CARVE: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Table access and result selection
  always_comb begin
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = count_q[IDX_W-1:0];
    wr_data     = {1'b1, size_q, used_q};
    res_set     = 1'b0;
    res_address = '0;
    res_status  = STAT_NULL;
    case (state_q)
      ST_IDLE: begin
        if (accept && null_free) begin
          res_set    = 1'b1;
          res_status = STAT_NULL;
        end
      end
      ST_SCAN: begin
        rd_en = !match && (idx_q != count_q);
        if (scan_end && (mode_q == MODE_FREE)) begin
          res_set    = 1'b1;
          res_status = STAT_REJECT;
        end
      end
      ST_HIT: begin
        wr_addr = hit_idx_q;
        wr_data = {(mode_q == MODE_ALLOC), hit_size, hit_off};
        res_set = 1'b1;
        if (mode_q == MODE_ALLOC) begin
          wr_en       = 1'b1;
          res_address = heap_base_q + ADDR_W'(hit_off) + HdrAddr;
          res_status  = STAT_REUSED;
        end else begin
          wr_en      = hit_in_use;
          res_status = hit_in_use ? STAT_FREED : STAT_REJECT;
        end
      end
      ST_CARVE: begin
        res_set = 1'b1;
        if (carve_ok) begin
          wr_en       = 1'b1;
          res_address = heap_base_q + ADDR_W'(used_q) + HdrAddr;
          res_status  = STAT_NEW;
        end else begin
          res_status = STAT_NOMEM;
        end
      end
      default: begin
        res_set = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      chk_vld_q   <= 1'b0;
      used_q      <= '0;
      heap_base_q <= '0;
      heap_len_q  <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      done_q    <= res_set;
      chk_vld_q <= rd_en;
      if (accept) begin
        idx_q <= '0;
      end else if (rd_en) begin
        idx_q <= idx_q + 1'b1;
      end
      // advance the bump pointer on a new block
      if ((state_q == ST_CARVE) && carve_ok) begin
        count_q <= count_q + 1'b1;
        used_q  <= end_w[OFF_W-1:0];
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_HEAP_BASE:   heap_base_q <= cfg_wdata_i;
          REG_HEAP_LENGTH: heap_len_q  <= cfg_wdata_i[LEN_W-1:0];
          default:         heap_base_q <= heap_base_q;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= mode_i;
      size_q   <= request_size_i[SZ_W-1:0];
      // offset that a freed block must carry to match the address
      target_q <= free_address_i - heap_base_q - HdrAddr;
    end
    if ((state_q == ST_SCAN) && match) begin
      hit_q     <= rd_data;
      hit_idx_q <= IDX_W'(idx_q - 1'b1);
    end
    if (res_set) begin
      address_q <= res_address;
      status_q  <= res_status;
    end
  end

  assign busy_o    = (state_q != ST_IDLE);
  assign done_o    = done_q;
  assign address_o = address_q;
  assign status_o  = status_q;

endmodule : exact_fit_block_allocator
`default_nettype wire

FILE: hw/rtl/efba_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// efba_checker: port-level checks of the exact-fit block allocator
// Watches requests and result beats on the top level's ports.
// ----------------------------------------------------------------------------
module efba_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         start_i,
  input wire logic                         mode_i,
  input wire logic [efba_pkg::ADDR_W-1:0]  free_address_i,
  input wire logic                         busy_o,
  input wire logic                         done_o,
  input wire logic [efba_pkg::ADDR_W-1:0]  address_o,
  input wire logic [2:0]                   status_o
);
  import efba_pkg::*;

  // A result beat carries a defined status code
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o <= STAT_NULL))
    else $error("result beat with undefined status");

  // Failures and every free give a zero address
  a_zero_address: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == STAT_NOMEM || status_o == STAT_FREED ||
               status_o == STAT_REJECT || status_o == STAT_NULL)
    |-> (address_o == '0))
    else $error("nonzero address on a failed or free result");

  // A null free answers in the next cycle without going busy
  a_null_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (mode_i == MODE_FREE) && (free_address_i == '0)
    |=> done_o && !busy_o && (status_o == STAT_NULL))
    else $error("null free not answered in one cycle");

  // A scan cannot produce a result in the cycle it begins
  a_no_early_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> !done_o)
    else $error("result beat as a scan begins");

endmodule : efba_checker

bind exact_fit_block_allocator efba_checker u_efba_checker (.*);
`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the exact-fit block allocator
// A scripted opening phase covers resets values, wrap, strict heap bound,
// reuse and free rejection. Randomized phases under several base and length
// settings follow. Every result beat is compared with the scripted expectation
// where a row gives one, and otherwise with a shadow allocator.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import efba_pkg::*;

  localparam int MAX_BLK    = 256;
  localparam int HDR        = 40;
  localparam int SZ_BITS    = 24;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN      = MAX_BLK + 40;
  localparam int PHASE_LEN  = 150;
  localparam int ALLOC_PCT [6] = '{85, 85, 60, 60, 50, 60};

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_e;

  // one scripted step: a request, or a register write (idx and word)
  typedef struct packed {
    row_kind_e               kind;
    logic                    mode;
    logic [REQ_W-1:0]        size;
    logic [ADDR_W-1:0]       word;
    logic [CFG_IDX_W-1:0]    idx;
    logic                    typed;
    logic [ADDR_W-1:0]       addr;
    efba_status_e            stat;
  } script_row_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    efba_status_e      status;
  } grant_t;

  localparam script_row_t SCRIPT [25] = '{
    // registers still at reset: no heap at all
    '{ROW_REQ, MODE_ALLOC, 24'd5,      32'h0,         REG_HEAP_BASE, 1'b1, 32'h0, STAT_NOMEM},
    '{ROW_REQ, MODE_FREE,  24'd0,      32'h0,         REG_HEAP_BASE, 1'b1, 32'h0, STAT_NULL},
    '{ROW_REQ, MODE_FREE,  24'hFFFFFF, 32'hFFFFFFFF,  REG_HEAP_BASE, 1'b1, 32'h0, STAT_REJECT},
    // base near the top so data addresses wrap
    '{ROW_CFG, MODE_ALLOC, 24'd0,      32'hFFFFFFF0,  REG_HEAP_BASE,   1'b0, 32'h0, STAT_REUSED},
    '{ROW_CFG, MODE_ALLOC, 24'd0,      32'd100,       REG_HEAP_LENGTH, 1'b0, 32'h0, STAT_REUSED},
    '{ROW_REQ, MODE_ALLOC, 24'd0,      32'h0,         REG_HEAP_BASE, 1'b1, 32'h18, STAT_NEW},
    '{ROW_REQ, MODE_ALLOC, 24'd19,     32'h0,         REG_HEAP_BASE, 1'b1, 32'h40, STAT_NEW},
    '{ROW_REQ, MODE_ALLOC, 24'd0,      32'h0,         REG_HEAP_BASE, 1'b1, 32'h0,  STAT_NOMEM},
    '{ROW_REQ, MODE_FREE,  24'd0,      32'h18,        REG_HEAP_BASE, 1'b1, 32'h0,  STAT_FREED},
    '{ROW_REQ, MODE_FREE,  24'd0,      32'h18,        REG_HEAP_BASE, 1'b1, 32'h0,  STAT_REJECT},
    '{ROW_REQ, MODE_ALLOC, 24'd0,      32'h0,         REG_HEAP_BASE, 1'b1, 32'h18, STAT_REUSED},
    '{ROW_REQ, MODE_FREE,  24'd0,      32'h40,        REG_HEAP_BASE, 1'b1, 32'h0,  STAT_FREED},
    // moved base: old addresses no longer match
    '{ROW_CFG, MODE_ALLOC, 24'd0,      32'h1000,      REG_HEAP_BASE, 1'b0, 32'h0,  STAT_REUSED},
    '{ROW_REQ, MODE_FREE,  24'd0,      32'h40,        REG_HEAP_BASE, 1'b1, 32'h0,  STAT_REJECT},
    '{ROW_REQ, MODE_ALLOC, 24'd19,     32'h0,         REG_HEAP_BASE, 1'b1, 32'h1050, STAT_REUSED},
    // strict bound: ending exactly at the heap length is refused
    '{ROW_CFG, MODE_ALLOC, 24'd0,      32'd149,       REG_HEAP_LENGTH, 1'b0, 32'h0, STAT_REUSED},
    '{ROW_REQ, MODE_ALLOC, 24'd10,     32'h0,         REG_HEAP_BASE, 1'b1, 32'h0,    STAT_NOMEM},
    '{ROW_REQ, MODE_ALLOC, 24'd9,      32'h0,         REG_HEAP_BASE, 1'b1, 32'h108B, STAT_NEW},
    '{ROW_CFG, MODE_ALLOC, 24'd0,      32'h01000000,  REG_HEAP_LENGTH, 1'b0, 32'h0, STAT_REUSED},
    '{ROW_REQ, MODE_ALLOC, 24'hFFFFFF, 32'hFFFFFFFF,  REG_HEAP_BASE, 1'b1, 32'h0,    STAT_NOMEM},
    '{ROW_REQ, MODE_FREE,  24'h0,      32'h1028,      REG_HEAP_BASE, 1'b0, 32'h0,    STAT_REUSED},
    // length dropped below the carved bytes: only reuse can succeed
    '{ROW_CFG, MODE_ALLOC, 24'd0,      32'd0,         REG_HEAP_LENGTH, 1'b0, 32'h0, STAT_REUSED},
    '{ROW_REQ, MODE_ALLOC, 24'd7,      32'h0,         REG_HEAP_BASE, 1'b1, 32'h0,    STAT_NOMEM},
    '{ROW_REQ, MODE_ALLOC, 24'd0,      32'h0,         REG_HEAP_BASE, 1'b1, 32'h1028, STAT_REUSED},
    '{ROW_REQ, MODE_FREE,  24'hFFFFFF, 32'h108B,      REG_HEAP_BASE, 1'b0, 32'h0,    STAT_REUSED}
  };

  logic                  clk_i;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i      = REG_HEAP_BASE;
  logic [CFG_DATA_W-1:0] cfg_wdata_i    = '0;
  logic                  start_i        = 1'b0;
  logic                  mode_i         = MODE_ALLOC;
  logic [REQ_W-1:0]      request_size_i = '0;
  logic [ADDR_W-1:0]     free_address_i = '0;
  logic                  busy_o;
  logic                  done_o;
  logic [ADDR_W-1:0]     address_o;
  logic [2:0]            status_o;

  // shadow allocator state
  logic [ADDR_W-1:0]  base_shadow;
  logic [LEN_W-1:0]   length_shadow;
  logic [REQ_W-1:0]   blk_size  [MAX_BLK];
  bit                 blk_taken [MAX_BLK];
  logic [OFF_W-1:0]   blk_off   [MAX_BLK];
  int                 blk_count;
  logic [OFF_W-1:0]   bytes_carved;

  grant_t pending_grants [$];
  int     err_count;
  int     idle_cycles;
  int     burst_left;

  exact_fit_block_allocator #(
    .MAX_BLOCKS  (MAX_BLK),
    .HEADER_BYTES(HDR),
    .SIZE_BITS   (SZ_BITS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start_i       (start_i),
    .mode_i        (mode_i),
    .request_size_i(request_size_i),
    .free_address_i(free_address_i),
    .busy_o        (busy_o),
    .done_o        (done_o),
    .address_o     (address_o),
    .status_o      (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [ADDR_W-1:0] blk_addr(input int i);
    return base_shadow + ADDR_W'(blk_off[i]) + ADDR_W'(HDR);
  endfunction

  // advance the shadow allocator by one accepted request
  function automatic grant_t heap_step(input logic mode, input logic [REQ_W-1:0] size,
                                       input logic [ADDR_W-1:0] faddr);
    grant_t          g;
    bit              hit;
    longint unsigned end_off;
    g.addr = '0;
    hit    = 1'b0;
    if (mode == MODE_ALLOC) begin
      g.status = STAT_NOMEM;
      // oldest free block of the exact size wins
      for (int i = 0; i < blk_count && !hit; i++) begin
        if (blk_size[i] == size && !blk_taken[i]) begin
          blk_taken[i] = 1'b1;
          g.addr       = blk_addr(i);
          g.status     = STAT_REUSED;
          hit          = 1'b1;
        end
      end
      // carve at the bump offset
      if (!hit) begin
        end_off = longint'(bytes_carved) + HDR + longint'(size);
        if (end_off < longint'(length_shadow) && blk_count < MAX_BLK) begin
          blk_size[blk_count]  = size;
          blk_taken[blk_count] = 1'b1;
          blk_off[blk_count]   = bytes_carved;
          g.addr               = blk_addr(blk_count);
          g.status             = STAT_NEW;
          blk_count++;
          bytes_carved = OFF_W'(end_off);
        end
      end
    end else if (faddr == '0) begin
      g.status = STAT_NULL;
    end else begin
      g.status = STAT_REJECT;
      for (int i = 0; i < blk_count && !hit; i++) begin
        if (blk_addr(i) == faddr) begin
          hit = 1'b1;
          if (blk_taken[i]) begin
            blk_taken[i] = 1'b0;
            g.status     = STAT_FREED;
          end
        end
      end
    end
    return g;
  endfunction

  // mostly back to back, some short gaps, a few long ones, bursts with none
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst_left = $urandom_range(10, 30);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [REQ_W-1:0] pick_size(input bit wide);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return REQ_W'($urandom_range(0, 31));
    if (r < 97 || !wide) return REQ_W'($urandom_range(0, 4095));
    return REQ_W'($urandom);
  endfunction

  // mostly live blocks, some freed ones, near misses, junk and null
  function automatic logic [ADDR_W-1:0] pick_free_addr();
    int unsigned r;
    int          idx;
    r = $urandom_range(0, 99);
    if (blk_count == 0 || r >= 90) return (r >= 95) ? '0 : ADDR_W'($urandom);
    idx = $urandom_range(0, blk_count - 1);
    if (r < 50) begin
      for (int t = 0; t < 8 && !blk_taken[idx]; t++) idx = $urandom_range(0, blk_count - 1);
    end
    if (r >= 80) return blk_addr(idx) + ADDR_W'($urandom_range(1, 3));
    return blk_addr(idx);
  endfunction

  // present one request, hold it until accepted, then queue its expected beat
  task automatic submit(input logic mode, input logic [REQ_W-1:0] size,
                        input logic [ADDR_W-1:0] faddr, input int unsigned gap,
                        input logic typed, input logic [ADDR_W-1:0] t_addr,
                        input efba_status_e t_stat);
    grant_t g;
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    mode_i         <= mode;
    request_size_i <= size;
    free_address_i <= faddr;
    do @(posedge clk_i); while (busy_o);
    g = heap_step(mode, size, faddr);
    if (typed) begin
      g.addr   = t_addr;
      g.status = t_stat;
    end
    pending_grants.push_back(g);
  endtask

  // drain outstanding work, then write one register
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    start_i <= 1'b0;
    while (pending_grants.size() != 0 || busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_HEAP_BASE) begin
      base_shadow = data;
    end else begin
      length_shadow = data[LEN_W-1:0];
    end
  endtask

  // stimulus
  initial begin : stim
    longint unsigned cap;
    logic [ADDR_W-1:0] base_val;
    base_shadow   = '0;
    length_shadow = '0;
    blk_count     = 0;
    bytes_carved  = '0;
    err_count     = 0;
    burst_left    = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // scripted opening
    for (int k = 0; k < 25; k++) begin
      if (SCRIPT[k].kind == ROW_CFG) begin
        write_reg(SCRIPT[k].idx, SCRIPT[k].word);
      end else begin
        submit(SCRIPT[k].mode, SCRIPT[k].size, SCRIPT[k].word, pick_gap(),
               SCRIPT[k].typed, SCRIPT[k].addr, SCRIPT[k].stat);
      end
    end

    // random phases under different base and length settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       base_val = 32'hFFFFFFFF;
        2:       base_val = 32'h0;
        4:       base_val = 32'hFFFFFFD8;  // first block sits at address zero
        default: base_val = $urandom;
      endcase
      write_reg(REG_HEAP_BASE, base_val);
      case (ph)
        3: begin
          cap = longint'(bytes_carved) + $urandom_range(0, 3000);
          if (cap > 64'd16777216) cap = 64'd16777216;
          write_reg(REG_HEAP_LENGTH, CFG_DATA_W'(cap));
        end
        4:       write_reg(REG_HEAP_LENGTH, 32'd0);
        default: write_reg(REG_HEAP_LENGTH, 32'd16777216);
      endcase
      for (int n = 0; n < PHASE_LEN; n++) begin
        if ($urandom_range(0, 99) < ALLOC_PCT[ph]) begin
          submit(MODE_ALLOC, pick_size(ph == 5), ADDR_W'($urandom), pick_gap(),
                 1'b0, '0, STAT_REUSED);
        end else begin
          submit(MODE_FREE, REQ_W'($urandom), pick_free_addr(), pick_gap(),
                 1'b0, '0, STAT_REUSED);
        end
      end
    end

    // drain and let the block settle
    start_i <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk_i) begin : check_results
    grant_t want;
    if (rst_ni && done_o) begin
      if (pending_grants.size() == 0) begin
        $error("unexpected result beat: address %h status %0d", address_o, status_o);
        err_count++;
      end else begin
        want = pending_grants.pop_front();
        if (address_o !== want.addr) begin
          $error("address: expected %h, actual %h", want.addr, address_o);
          err_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          err_count++;
        end
      end
    end
  end

  // stop a hung run: count cycles with neither a request nor a result beat
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial idle_cycles = 0;

endmodule

FILE: filelist.f
hw/rtl/efba_pkg.sv
hw/rtl/efba_table.sv
hw/rtl/exact_fit_block_allocator.sv
hw/rtl/efba_checker.sv
tb/tb_top.sv
